>>> design/fkis_pkg.sv
// ----------------------------------------------------------------------------
// fkis_pkg - shared types and constants for the FLV keyframe index scanner
// Tag preamble byte offsets, video keyframe codes and the index entry type.
// ----------------------------------------------------------------------------
package fkis_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 24;
  localparam int unsigned PIDX_W    = 4;

  localparam logic [ADDR_W-1:0] START_OFFSET_RESET = 32'd9;

  // Tag type and frame type codes
  localparam logic [7:0] TAG_VIDEO       = 8'h09;
  localparam logic [7:0] FRAME_TYPE_MASK = 8'hf0;
  localparam logic [7:0] FRAME_KEY       = 8'h10;

  // Preamble byte offsets
  localparam logic [PIDX_W-1:0] PRE_TAG_START = 4'd0;
  localparam logic [PIDX_W-1:0] PRE_TYPE      = 4'd4;
  localparam logic [PIDX_W-1:0] PRE_SIZE_HI   = 4'd5;
  localparam logic [PIDX_W-1:0] PRE_SIZE_MID  = 4'd6;
  localparam logic [PIDX_W-1:0] PRE_SIZE_LO   = 4'd7;
  localparam logic [PIDX_W-1:0] PRE_TIME_HI   = 4'd8;
  localparam logic [PIDX_W-1:0] PRE_TIME_MID  = 4'd9;
  localparam logic [PIDX_W-1:0] PRE_TIME_LO   = 4'd10;
  localparam logic [PIDX_W-1:0] PRE_TIME_EXT  = 4'd11;
  localparam logic [PIDX_W-1:0] PRE_LAST      = 4'd14;

  typedef struct packed {
    logic [31:0] timestamp;
    logic [31:0] position;
    logic [31:0] number;
  } key_entry_t;

endpackage

>>> design/flv_keyframe_index_scanner.sv
// ----------------------------------------------------------------------------
// flv_keyframe_index_scanner - FLV tag stream keyframe index builder
// Parses tag preambles from a byte stream and emits one index entry per
// video keyframe tag: timestamp, preamble file position, entry number.
// ----------------------------------------------------------------------------
//
//  channel | signals                            | handshake
//  --------+------------------------------------+---------------------------
//  config  | cfg_we, cfg_data                   | write when cfg_we high
//  input   | data_byte, last_byte               | in_valid && !in_stall
//  output  | key_timestamp, key_position,       | out_valid && !out_stall
//          | key_number                         |
//
// One byte word is taken every cycle while in_stall is low; the parser state
// (position counter, preamble index, remaining data count) updates in the
// cycle of acceptance. A keyframe entry is registered when its first data
// byte is accepted. rst is synchronous, active high; it loads start offset 9
// and clears the keyframe counter. Output stalls are absorbed by a one-entry
// skid stage; in_stall rises only while that skid holds an entry.
// ----------------------------------------------------------------------------
module flv_keyframe_index_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] key_timestamp,
  output logic [31:0] key_position,
  output logic [31:0] key_number
);

  logic                 accept;
  logic                 hit;
  logic                 buf_full;
  fkis_pkg::key_entry_t entry;
  fkis_pkg::key_entry_t out_entry;

  // advance the parser on each accepted byte word
  assign accept   = in_valid && !in_stall;
  assign in_stall = buf_full;

  fkis_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .hit       (hit),
    .entry     (entry)
  );

  // hold entries until the consumer takes them
  fkis_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && hit),
    .push_entry (entry),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_entry  (out_entry)
  );

  assign key_timestamp = out_entry.timestamp;
  assign key_position  = out_entry.position;
  assign key_number    = out_entry.number;

endmodule

>>> design/fkis_parser.sv
// ----------------------------------------------------------------------------
// fkis_parser - tag preamble parser and keyframe detector
// Walks the tag stream one byte per accepted word and flags keyframe entries.
// ----------------------------------------------------------------------------
module fkis_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_data,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 hit,
  output fkis_pkg::key_entry_t entry
);

  logic [31:0]                 start_offset;
  logic [31:0]                 byte_position, byte_position_next;
  logic [fkis_pkg::PIDX_W-1:0] preamble_index, preamble_index_next;
  logic                        in_data_phase, in_data_phase_next;
  logic [7:0]                  tag_kind, tag_kind_next;
  logic [fkis_pkg::SIZE_W-1:0] payload_size, payload_size_next;
  logic [31:0]                 tag_time, tag_time_next;
  logic [31:0]                 tag_start, tag_start_next;
  logic [fkis_pkg::SIZE_W-1:0] payload_left, payload_left_next;
  logic [31:0]                 keyframe_count, keyframe_count_next;

  always_comb begin
    byte_position_next  = byte_position + 32'd1;
    preamble_index_next = preamble_index;
    in_data_phase_next  = in_data_phase;
    tag_kind_next       = tag_kind;
    payload_size_next   = payload_size;
    tag_time_next       = tag_time;
    tag_start_next      = tag_start;
    payload_left_next   = payload_left;
    keyframe_count_next = keyframe_count;
    hit                 = 1'b0;

    if (in_data_phase) begin
      hit = (payload_left == payload_size) && (tag_kind == fkis_pkg::TAG_VIDEO) &&
            ((data_byte & fkis_pkg::FRAME_TYPE_MASK) == fkis_pkg::FRAME_KEY);
      if (hit && (keyframe_count != 32'hffff_ffff)) begin
        keyframe_count_next = keyframe_count + 32'd1;
      end
      payload_left_next = payload_left - 24'd1;
      if (payload_left_next == '0) begin
        in_data_phase_next = 1'b0;
      end
    end else begin
      case (preamble_index)
        fkis_pkg::PRE_TAG_START: tag_start_next    = byte_position;
        fkis_pkg::PRE_TYPE:      tag_kind_next     = data_byte;
        fkis_pkg::PRE_SIZE_HI:   payload_size_next = {data_byte, 16'h0000};
        fkis_pkg::PRE_SIZE_MID:  payload_size_next = payload_size | {8'h00, data_byte, 8'h00};
        fkis_pkg::PRE_SIZE_LO:   payload_size_next = payload_size | {16'h0000, data_byte};
        fkis_pkg::PRE_TIME_HI:   tag_time_next     = {8'h00, data_byte, 16'h0000};
        fkis_pkg::PRE_TIME_MID:  tag_time_next     = tag_time | {16'h0000, data_byte, 8'h00};
        fkis_pkg::PRE_TIME_LO:   tag_time_next     = tag_time | {24'h000000, data_byte};
        fkis_pkg::PRE_TIME_EXT:  tag_time_next     = tag_time | {data_byte, 24'h000000};
        default: ;
      endcase
      if (preamble_index == fkis_pkg::PRE_LAST) begin
        preamble_index_next = '0;
        if (payload_size_next != '0) begin
          in_data_phase_next = 1'b1;
          payload_left_next  = payload_size_next;
        end
      end else begin
        preamble_index_next = preamble_index + 4'd1;
      end
    end

    // End of file: rewind to the start of a fresh preamble
    if (last_byte) begin
      preamble_index_next = '0;
      in_data_phase_next  = 1'b0;
      payload_left_next   = '0;
      byte_position_next  = start_offset;
    end
  end

  assign entry.timestamp = tag_time;
  assign entry.position  = tag_start;
  assign entry.number    = keyframe_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset   <= fkis_pkg::START_OFFSET_RESET;
      byte_position  <= fkis_pkg::START_OFFSET_RESET;
      preamble_index <= '0;
      in_data_phase  <= 1'b0;
      tag_kind       <= '0;
      payload_size   <= '0;
      tag_time       <= '0;
      tag_start      <= '0;
      payload_left   <= '0;
      keyframe_count <= '0;
    end else if (cfg_we) begin
      start_offset  <= cfg_data;
      byte_position <= cfg_data;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      preamble_index <= preamble_index_next;
      in_data_phase  <= in_data_phase_next;
      tag_kind       <= tag_kind_next;
      payload_size   <= payload_size_next;
      tag_time       <= tag_time_next;
      tag_start      <= tag_start_next;
      payload_left   <= payload_left_next;
      keyframe_count <= keyframe_count_next;
    end
  end

endmodule

>>> design/fkis_out_buf.sv
// ----------------------------------------------------------------------------
// fkis_out_buf - result register with skid stage
// Holds index entries for the output channel; stalls input when the skid fills.
// ----------------------------------------------------------------------------
module fkis_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fkis_pkg::key_entry_t push_entry,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fkis_pkg::key_entry_t out_entry
);

  logic                 skid_valid;
  fkis_pkg::key_entry_t skid_entry;
  logic                 pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain skid into the output register
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_entry <= skid_entry;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_entry <= push_entry;
      end else begin
        skid_entry <= push_entry;
      end
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the FLV keyframe index scanner
// Feeds tag streams byte word by byte word (directed tags, then random files
// with truncated, empty and noise tags), predicts every index entry in step
// with acceptance and compares each output word field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  // Tag type codes the stream generator uses besides video
  localparam logic [7:0] TAG_AUDIO  = 8'h08;
  localparam logic [7:0] TAG_SCRIPT = 8'h12;

  localparam int PREAMBLE_BYTES = 15;
  localparam int HOLD_CYCLES    = 240;     // long receiver hold-off
  localparam int SETTLE_CYCLES  = 16;      // settle wait after draining
  localparam int CYCLE_LIMIT    = 300000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] key_timestamp;
  logic [31:0] key_position;
  logic [31:0] key_number;

  // Idling and pressure controls, driven only by the stimulus block
  logic idle_en  = 1'b1;
  logic hold_req = 1'b0;

  stream_word_t         word_q[$];   // words waiting to be offered
  fkis_pkg::key_entry_t key_q[$];    // index entries still owed by the block

  int err_count   = 0;
  int n_queued    = 0;
  int n_accepted  = 0;
  int n_entries   = 0;
  int n_configs   = 0;
  int cycle_count = 0;

  // Scanner state as the bench sees it
  logic [31:0] start_off;
  logic [31:0] cur_pos;
  logic [3:0]  pre_idx;
  logic        in_payload;
  logic [7:0]  kind;
  logic [23:0] tag_size;
  logic [31:0] stamp;
  logic [31:0] tag_pos;
  logic [23:0] remain;
  logic [31:0] key_count;

  flv_keyframe_index_scanner DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .key_timestamp (key_timestamp),
    .key_position  (key_position),
    .key_number    (key_number)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the scanner state by one accepted word; queue the index entry
  // that a keyframe's first data byte produces.
  function automatic void scan_word(input logic [7:0] d, input logic l);
    fkis_pkg::key_entry_t e;
    if (in_payload) begin
      // Only the first data byte of a video tag can mark a keyframe
      if (remain == tag_size && kind == fkis_pkg::TAG_VIDEO &&
          (d & fkis_pkg::FRAME_TYPE_MASK) == fkis_pkg::FRAME_KEY) begin
        e.timestamp = stamp;
        e.position  = tag_pos;
        e.number    = key_count;
        key_q.push_back(e);
        if (key_count != '1) key_count++;   // saturate, never wrap
      end
      remain = remain - 24'd1;
      if (remain == '0) in_payload = 1'b0;
    end else begin
      case (pre_idx)
        fkis_pkg::PRE_TAG_START: tag_pos  = cur_pos;
        fkis_pkg::PRE_TYPE:      kind     = d;
        fkis_pkg::PRE_SIZE_HI:   tag_size = {d, 16'h0000};
        fkis_pkg::PRE_SIZE_MID:  tag_size = tag_size | {8'h00, d, 8'h00};
        fkis_pkg::PRE_SIZE_LO:   tag_size = tag_size | {16'h0000, d};
        fkis_pkg::PRE_TIME_HI:   stamp    = {8'h00, d, 16'h0000};
        fkis_pkg::PRE_TIME_MID:  stamp    = stamp | {16'h0000, d, 8'h00};
        fkis_pkg::PRE_TIME_LO:   stamp    = stamp | {24'h000000, d};
        fkis_pkg::PRE_TIME_EXT:  stamp    = stamp | {d, 24'h000000};
        default: ;
      endcase
      if (pre_idx == fkis_pkg::PRE_LAST) begin
        pre_idx = fkis_pkg::PRE_TAG_START;
        // An empty tag goes straight on to the next preamble
        if (tag_size != '0) begin
          in_payload = 1'b1;
          remain     = tag_size;
        end
      end else begin
        pre_idx++;
      end
    end
    cur_pos = cur_pos + 32'd1;   // wraps at the top of the address space
    // The last word of a file rewinds the parser but keeps the entry count
    if (l) begin
      pre_idx    = fkis_pkg::PRE_TAG_START;
      in_payload = 1'b0;
      remain     = '0;
      cur_pos    = start_off;
    end
  endfunction

  function automatic void check_entry();
    fkis_pkg::key_entry_t e;
    if (key_q.size() == 0) begin
      $error("unexpected entry: key_timestamp %h key_position %h key_number %h",
             key_timestamp, key_position, key_number);
      err_count++;
      return;
    end
    e = key_q.pop_front();
    n_entries++;
    if (key_timestamp !== e.timestamp) begin
      $error("key_timestamp: expected %h, got %h", e.timestamp, key_timestamp);
      err_count++;
    end
    if (key_position !== e.position) begin
      $error("key_position: expected %h, got %h", e.position, key_position);
      err_count++;
    end
    if (key_number !== e.number) begin
      $error("key_number: expected %h, got %h", e.number, key_number);
      err_count++;
    end
  endfunction

  // Driver: predict on acceptance, then hold a stalled word or offer the
  // next one, with random idle gaps while idling is enabled.
  always @(posedge clk) begin : drive
    stream_word_t w;
    int unsigned  send_gap;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_word(data_byte, last_byte);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_en && word_q.size() != 0 && $urandom_range(0, 19) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (word_q.size() != 0) begin
          w = word_q.pop_front();
          in_valid  <= 1'b1;
          data_byte <= w.data;
          last_byte <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted entry, then decide the stall for the next
  // cycle. The long hold-off is counted here, once, on request.
  always @(posedge clk) begin : watch
    int unsigned stall_left;
    logic        hold_taken;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) check_entry();
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] d, input logic l);
    stream_word_t w;
    w.data = d;
    w.last = l;
    word_q.push_back(w);
    n_queued++;
  endtask

  // Queue one tag. cut = 0 emits it whole with no end of file; otherwise
  // emit at most cut words and mark the final one as the last of the file.
  task automatic queue_tag(input logic [7:0] k, input logic [23:0] sz,
                           input logic [31:0] ts, input logic [7:0] lead,
                           input int cut);
    logic [7:0] pre [PREAMBLE_BYTES];
    int         total;
    int         n;
    logic [7:0] d;
    total = PREAMBLE_BYTES + int'(sz);
    n = (cut > 0 && cut < total) ? cut : total;
    for (int i = 0; i < PREAMBLE_BYTES; i++) pre[i] = 8'($urandom_range(0, 255));
    pre[fkis_pkg::PRE_TYPE]     = k;
    pre[fkis_pkg::PRE_SIZE_HI]  = sz[23:16];
    pre[fkis_pkg::PRE_SIZE_MID] = sz[15:8];
    pre[fkis_pkg::PRE_SIZE_LO]  = sz[7:0];
    pre[fkis_pkg::PRE_TIME_HI]  = ts[23:16];
    pre[fkis_pkg::PRE_TIME_MID] = ts[15:8];
    pre[fkis_pkg::PRE_TIME_LO]  = ts[7:0];
    pre[fkis_pkg::PRE_TIME_EXT] = ts[31:24];
    for (int i = 0; i < n; i++) begin
      if (i < PREAMBLE_BYTES) d = pre[i];
      else if (i == PREAMBLE_BYTES) d = lead;
      else d = 8'($urandom_range(0, 255));
      push_word(d, cut > 0 && i == n - 1);
    end
  endtask

  // Mostly video tags with small payloads and keyframe lead bytes; a few
  // huge sizes, always cut short by an early end of file.
  task automatic queue_random_tag(input bit final_tag);
    logic [7:0]  k;
    logic [7:0]  lead;
    logic [23:0] sz;
    logic [31:0] ts;
    int          pick;
    int          cut;
    pick = $urandom_range(0, 9);
    if (pick < 7) k = fkis_pkg::TAG_VIDEO;
    else if (pick == 7) k = TAG_AUDIO;
    else if (pick == 8) k = TAG_SCRIPT;
    else k = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    if (pick < 4) sz = '0;
    else if (pick < 17) sz = 24'($urandom_range(1, 12));
    else if (pick < 19) sz = 24'($urandom_range(13, 300));
    else sz = 24'($urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 3) != 0) lead = fkis_pkg::FRAME_KEY | 8'($urandom_range(0, 15));
    else lead = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 7);
    if (pick == 0) ts = '0;
    else if (pick == 1) ts = '1;
    else ts = $urandom;
    cut = 0;
    if (sz > 24'd300) begin
      cut = $urandom_range(1, 40);
    end else if (final_tag) begin
      cut = PREAMBLE_BYTES + int'(sz);
      if ($urandom_range(0, 2) == 0) cut = $urandom_range(1, cut);
    end
    queue_tag(k, sz, ts, lead, cut);
  endtask

  // Queue files until about n more words wait; one file in ten is noise.
  task automatic queue_files(input int n);
    int goal;
    int tags;
    int len;
    goal = n_queued + n;
    while (n_queued < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) push_word(8'($urandom_range(0, 255)), i == len - 1);
      end else begin
        tags = $urandom_range(1, 6);
        for (int t = 0; t < tags; t++) queue_random_tag(t == tags - 1);
      end
    end
  endtask

  // Wait until every word is taken and every entry has come back, then let
  // the pipeline settle before touching the register.
  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid || key_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [31:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    // The write lands at this edge: reload the position, keep the phase
    start_off = v;
    cur_pos   = v;
    n_configs++;
  endtask

  initial begin
    start_off  = fkis_pkg::START_OFFSET_RESET;
    cur_pos    = fkis_pkg::START_OFFSET_RESET;
    pre_idx    = fkis_pkg::PRE_TAG_START;
    in_payload = 1'b0;
    kind       = '0;
    tag_size   = '0;
    stamp      = '0;
    tag_pos    = '0;
    remain     = '0;
    key_count  = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tag, keyframe with all-ones timestamp, keyframe whose
    // lead byte ends the file, end of file inside a preamble.
    queue_tag(fkis_pkg::TAG_VIDEO, 24'd0, 32'h0000_0000, 8'h00, 0);
    queue_tag(fkis_pkg::TAG_VIDEO, 24'd2, 32'hFFFF_FFFF, 8'h1F, 0);
    queue_tag(fkis_pkg::TAG_VIDEO, 24'd1, 32'h8000_0001, fkis_pkg::FRAME_KEY,
              PREAMBLE_BYTES + 1);
    queue_tag(fkis_pkg::TAG_VIDEO, 24'd1, 32'h0123_4567, fkis_pkg::FRAME_KEY, 3);
    wait_drained();

    // Lowest offset
    write_start(32'h0000_0000);
    queue_files(350);
    wait_drained();

    // Positions wrap past the top mid-file
    write_start(32'hFFFF_FFF8);
    queue_files(250);
    wait_drained();

    // Highest offset; hold the receiver off while dense keyframes keep
    // coming so the skid fills and the input stalls.
    write_start(32'hFFFF_FFFF);
    hold_req <= 1'b1;
    for (int i = 0; i < 25; i++)
      queue_tag(fkis_pkg::TAG_VIDEO, 24'd1, $urandom,
                fkis_pkg::FRAME_KEY | 8'($urandom_range(0, 15)), 0);
    push_word(8'h00, 1'b1);
    wait_drained();

    write_start($urandom);
    queue_files(250);
    wait_drained();

    // Back to the reset offset, no idling on either side
    write_start(fkis_pkg::START_OFFSET_RESET);
    idle_en <= 1'b0;
    queue_files(200);
    wait_drained();

    if (key_q.size() != 0) begin
      $error("%0d index entries never arrived", key_q.size());
      err_count++;
    end
    $display("Scanned %0d stream words under %0d start offsets;", n_accepted, n_configs + 1);
    $display("%0d keyframe index entries compared, with stalls and a long hold-off.",
             n_entries);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
